FILE: sv/apmm_pkg.sv
// apmm_pkg: shared types, register indexes, reset values and fixed constants
// for the axis pi motor mixer; no dependencies
package apmm_pkg;

	localparam int ANGLE_W = 16;
	localparam int SPEED_W = 12;
	localparam int DRIVE_W = 14;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 3;

	// axis range in hundredths of a degree
	localparam logic [15:0] ROLL_RANGE = 16'd36000;
	localparam logic [15:0] PITCH_RANGE = 16'd18000;

	// the range's power-of-two factor is folded into the shift, leaving
	// floor((diff * 2^shift + 562) / 1125) for either axis
	localparam int ROLL_SHIFT = 10;
	localparam int PITCH_SHIFT = 11;
	localparam logic [10:0] ERR_DIV = 11'd1125;
	localparam logic [9:0] ERR_ROUND = 10'd562;
	// floor(x / 1125) = (x * ERR_RECIP) >> ERR_SHIFT, exact for x below 2^26
	localparam logic [23:0] ERR_RECIP = 24'd15270995;
	localparam int ERR_SHIFT = 34;
	localparam logic [25:0] ERR_MAG_MAX = 26'h3ff_ffff;

	localparam logic [16:0] Q15_ONE = 17'd32768;
	localparam logic [11:0] MOTOR_MAX = 12'd4095;

	localparam logic [15:0] KP_RESET = 16'd2335;
	localparam logic [23:0] KI_RESET = 24'd28521;
	localparam logic [11:0] MAX_SPEED_RESET = 12'd1250;
	localparam logic [11:0] MIN_SPEED_RESET = 12'd625;
	localparam logic [15:0] SETPOINT_RESET = 16'd0;
	localparam logic [11:0] SCALE_RESET = 12'd625;
	localparam logic MODE_RESET = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_GAIN = 3'd0,
		CFG_KI_GAIN = 3'd1,
		CFG_MAX_SPEED = 3'd2,
		CFG_MIN_SPEED = 3'd3,
		CFG_SETPOINT = 3'd4,
		CFG_DRIVE_SCALE = 3'd5,
		CFG_AXIS_MODE = 3'd6
	} apmm_cfg_idx_t;

	typedef enum logic {
		OP_STEP = 1'b0,
		OP_CLEAR = 1'b1
	} apmm_op_t;

	typedef enum logic {
		MODE_ROLL = 1'b0,
		MODE_PITCH = 1'b1
	} apmm_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MULE,
		ST_ERR,
		ST_SUM,
		ST_MULI,
		ST_MULP,
		ST_MIX,
		ST_MULD,
		ST_DRV,
		ST_FIN
	} apmm_state_t;

	typedef struct packed {
		logic [15:0] kp_gain;
		logic [23:0] ki_gain;
		logic [11:0] max_speed;
		logic [11:0] min_speed;
		logic signed [15:0] setpoint_angle;
		logic [11:0] drive_scale;
		logic axis_mode;
	} apmm_cfg_t;

	typedef struct packed {
		logic cap_in;
		logic clr;
		logic prep;
		logic mul_e;
		logic err;
		logic sum;
		logic mul_i;
		logic mul_p;
		logic mix;
		logic mul_d;
		logic drv;
		logic out_load;
	} apmm_ctrl_t;

endpackage

FILE: sv/apmm_if.sv
// apmm channel interfaces: input transaction and result transaction
// depends on nothing; widths match apmm_pkg field widths
interface apmm_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [15:0] measured_angle;
	logic [11:0] base_speed;

	modport source (output valid, output opcode, output measured_angle, output base_speed,
		input ready);
	modport sink (input valid, input opcode, input measured_angle, input base_speed,
		output ready);
endinterface

interface apmm_out_if;
	logic valid;
	logic ready;
	logic [11:0] first_motor;
	logic [11:0] second_motor;
	logic signed [13:0] drive_value;

	modport source (output valid, output first_motor, output second_motor,
		output drive_value, input ready);
	modport sink (input valid, input first_motor, input second_motor, input drive_value,
		output ready);
endinterface

FILE: sv/apmm_regs.sv
// apmm_regs: configuration register file written through a plain write port
// depends on apmm_pkg
module apmm_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [apmm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [apmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output apmm_pkg::apmm_cfg_t cfg
);
	import apmm_pkg::*;

	apmm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain <= KP_RESET;
			cfg_q.ki_gain <= KI_RESET;
			cfg_q.max_speed <= MAX_SPEED_RESET;
			cfg_q.min_speed <= MIN_SPEED_RESET;
			cfg_q.setpoint_angle <= SETPOINT_RESET;
			cfg_q.drive_scale <= SCALE_RESET;
			cfg_q.axis_mode <= MODE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_KP_GAIN: cfg_q.kp_gain <= cfg_wdata[15:0];
				CFG_KI_GAIN: cfg_q.ki_gain <= cfg_wdata[23:0];
				CFG_MAX_SPEED: cfg_q.max_speed <= cfg_wdata[11:0];
				CFG_MIN_SPEED: cfg_q.min_speed <= cfg_wdata[11:0];
				CFG_SETPOINT: cfg_q.setpoint_angle <= $signed(cfg_wdata[15:0]);
				CFG_DRIVE_SCALE: cfg_q.drive_scale <= cfg_wdata[11:0];
				CFG_AXIS_MODE: cfg_q.axis_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/apmm_seq.sv
// apmm_seq: sequencer for the shared multiplier, plus the valid flag of the
// result register; depends on apmm_pkg
module apmm_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_opcode,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output apmm_pkg::apmm_ctrl_t ctrl
);
	import apmm_pkg::*;

	apmm_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_opcode == OP_STEP) state_d = ST_PREP;
			ST_PREP: state_d = ST_MULE;
			ST_MULE: state_d = ST_ERR;
			ST_ERR: state_d = ST_SUM;
			ST_SUM: state_d = ST_MULI;
			ST_MULI: state_d = ST_MULP;
			ST_MULP: state_d = ST_MIX;
			ST_MIX: state_d = ST_MULD;
			ST_MULD: state_d = ST_DRV;
			ST_DRV: state_d = ST_FIN;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.cap_in = in_valid && in_opcode == OP_STEP;
				ctrl.clr = in_valid && in_opcode == OP_CLEAR;
			end
			ST_PREP: ctrl.prep = 1'b1;
			ST_MULE: ctrl.mul_e = 1'b1;
			ST_ERR: ctrl.err = 1'b1;
			ST_SUM: ctrl.sum = 1'b1;
			ST_MULI: ctrl.mul_i = 1'b1;
			ST_MULP: ctrl.mul_p = 1'b1;
			ST_MIX: ctrl.mix = 1'b1;
			ST_MULD: ctrl.mul_d = 1'b1;
			ST_DRV: ctrl.drv = 1'b1;
			ST_FIN: ctrl.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/apmm_dp.sv
// apmm_dp: datapath with one shared signed multiplier (error reciprocal, gains,
// drive scale), error sum, mixer and result register; depends on apmm_pkg
module apmm_dp (
	input  logic clk,
	input  logic arst_n,
	input  apmm_pkg::apmm_ctrl_t ctrl,
	input  apmm_pkg::apmm_cfg_t cfg,
	input  logic signed [apmm_pkg::ANGLE_W-1:0] measured_angle,
	input  logic [apmm_pkg::SPEED_W-1:0] base_speed,
	output logic [apmm_pkg::SPEED_W-1:0] first_motor,
	output logic [apmm_pkg::SPEED_W-1:0] second_motor,
	output logic signed [apmm_pkg::DRIVE_W-1:0] drive_value
);
	import apmm_pkg::*;

	logic signed [16:0] diff_q;
	logic [11:0] base_q;
	logic [25:0] mag_q;
	logic neg_q;
	logic signed [15:0] e_q;
	logic signed [31:0] error_sum_q;
	logic signed [56:0] prod_q;
	logic [16:0] ival_q;
	logic signed [20:0] mv_q;
	logic signed [18:0] drive_q;
	logic [11:0] first_q;
	logic [11:0] second_q;
	logic signed [13:0] drive_out_q;

	logic signed [28:0] num;
	logic [28:0] mag_full;
	logic [25:0] mag;
	logic [16:0] quo;
	logic signed [17:0] q_signed;
	logic signed [15:0] e_next;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_next;
	logic signed [31:0] mul_a;
	logic [23:0] mul_b;
	logic signed [56:0] mul_p;
	logic [32:0] prod_hi;
	logic [16:0] ival_next;
	logic signed [20:0] mv_next;
	logic signed [56:0] drv_sum;
	logic signed [18:0] drv_raw;
	logic signed [12:0] cap;
	logic signed [18:0] cap_w;
	logic signed [18:0] drive_next;
	logic signed [20:0] base_w;
	logic signed [20:0] drv_w;
	logic signed [20:0] max_w;
	logic signed [20:0] min_w;
	logic signed [20:0] first_raw;
	logic signed [20:0] second_raw;
	logic signed [20:0] first_ch;
	logic signed [20:0] second_ch;
	logic [11:0] first_sat;
	logic [11:0] second_sat;
	logic signed [13:0] drive_sat;

	// error numerator: diff * 2^shift + 562, divided by 1125 through the reciprocal
	always_comb begin
		if (cfg.axis_mode == MODE_PITCH) num = (29'(diff_q) <<< PITCH_SHIFT) + 29'(ERR_ROUND);
		else num = (29'(diff_q) <<< ROLL_SHIFT) + 29'(ERR_ROUND);
		// floor of a negative numerator: divide (-n + d - 1) and negate
		mag_full = num[28] ? (~num + 29'(ERR_DIV)) : num;
		// past this limit the error saturates either way
		mag = (mag_full > 29'(ERR_MAG_MAX)) ? ERR_MAG_MAX : mag_full[25:0];
	end

	always_comb begin
		quo = prod_q[ERR_SHIFT+16:ERR_SHIFT];
		q_signed = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		if (q_signed > 18'sd32767) e_next = 16'sh7fff;
		else if (q_signed < -18'sd32768) e_next = 16'sh8000;
		else e_next = q_signed[15:0];
		sum_wide = 33'(error_sum_q) + 33'(e_q);
		if (sum_wide > 33'sh0_7fff_ffff) sum_next = 32'sh7fff_ffff;
		else if (sum_wide < -33'sh0_8000_0000) sum_next = 32'sh8000_0000;
		else sum_next = sum_wide[31:0];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = error_sum_q;
		mul_b = cfg.ki_gain;
		if (ctrl.mul_e) begin
			mul_a = {6'd0, mag_q};
			mul_b = ERR_RECIP;
		end else if (ctrl.mul_p) begin
			mul_a = 32'(e_q);
			mul_b = {8'd0, cfg.kp_gain};
		end else if (ctrl.mul_d) begin
			mul_a = 32'(mv_q);
			mul_b = {12'd0, cfg.drive_scale};
		end
		mul_p = 57'(mul_a) * $signed({33'd0, mul_b});
	end

	always_comb begin
		// integral term is zero unless ki*sum is positive, capped at one
		prod_hi = prod_q[56:24];
		if (prod_q[56] || prod_q == '0) ival_next = '0;
		else if (prod_hi > {16'd0, Q15_ONE}) ival_next = Q15_ONE;
		else ival_next = prod_hi[16:0];
		mv_next = prod_q[32:12] + $signed({4'd0, ival_q});
		drv_sum = prod_q + 57'sd16384;
		drv_raw = drv_sum[33:15];
		cap = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, base_q});
		cap_w = 19'(cap);
		drive_next = (drv_raw > cap_w) ? cap_w : drv_raw;
	end

	always_comb begin
		base_w = $signed({9'd0, base_q});
		drv_w = 21'(drive_q);
		max_w = $signed({9'd0, cfg.max_speed});
		min_w = $signed({9'd0, cfg.min_speed});
		if (e_q[15]) begin
			first_raw = base_w - drv_w;
			second_raw = base_w;
		end else begin
			first_raw = base_w;
			second_raw = base_w + drv_w;
		end
		first_ch = first_raw;
		second_ch = second_raw;
		// roll clamp chain, first matching rule wins
		if (cfg.axis_mode == MODE_ROLL) begin
			if (first_raw > max_w) first_ch = base_w;
			else if (second_raw > max_w) second_ch = base_w;
			else if (first_raw < min_w) first_ch = min_w;
			else if (second_raw < min_w) second_ch = min_w;
		end
		if (first_ch[20]) first_sat = '0;
		else if (first_ch > $signed({9'd0, MOTOR_MAX})) first_sat = MOTOR_MAX;
		else first_sat = first_ch[11:0];
		if (second_ch[20]) second_sat = '0;
		else if (second_ch > $signed({9'd0, MOTOR_MAX})) second_sat = MOTOR_MAX;
		else second_sat = second_ch[11:0];
		if (drive_q > 19'sd8191) drive_sat = 14'sh1fff;
		else if (drive_q < -19'sd8192) drive_sat = 14'sh2000;
		else drive_sat = drive_q[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
		end else if (ctrl.clr) begin
			error_sum_q <= '0;
		end else if (ctrl.sum) begin
			error_sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap_in) begin
			diff_q <= 17'(measured_angle) - 17'(cfg.setpoint_angle);
			base_q <= base_speed;
		end
		if (ctrl.prep) begin
			mag_q <= mag;
			neg_q <= num[28];
		end
		if (ctrl.err) e_q <= e_next;
		if (ctrl.mul_e || ctrl.mul_i || ctrl.mul_p || ctrl.mul_d) prod_q <= mul_p;
		if (ctrl.mul_p) ival_q <= ival_next;
		if (ctrl.mix) mv_q <= mv_next;
		if (ctrl.drv) drive_q <= drive_next;
		if (ctrl.out_load) begin
			first_q <= first_sat;
			second_q <= second_sat;
			drive_out_q <= drive_sat;
		end
	end

	assign first_motor = first_q;
	assign second_motor = second_q;
	assign drive_value = drive_out_q;

endmodule

FILE: sv/axis_pi_motor_mixer_top.sv
// axis_pi_motor_mixer_top: pi attitude controller with motor mixing for one axis
// depends on apmm_pkg, apmm_if, apmm_regs, apmm_seq, apmm_dp
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        opcode, measured_angle, base_speed
//  out_ch   out  valid/ready        first_motor, second_motor, drive_value
//  cfg      in   cfg_wen only       cfg_idx, cfg_wdata
//
// a control step runs from acceptance to a loaded result through a setup state
// for the error numerator, a multiply by the reciprocal of the range, then the
// states around the shared multiplier and the mixer; the input opens again
// when the sequencer is back in idle
// a clear transaction is taken in idle, zeroes the error sum and gives no result
// the result register frees the input side: a new transaction is taken while a
// result waits; a finished step holds in its last state until that register frees
// asynchronous active-low reset returns control, configuration and the error sum
module axis_pi_motor_mixer_top (
	input  logic clk,
	input  logic arst_n,
	apmm_in_if.sink in_ch,
	apmm_out_if.source out_ch,
	input  logic cfg_wen,
	input  logic [apmm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [apmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import apmm_pkg::*;

	apmm_cfg_t cfg;
	apmm_ctrl_t ctrl;

	apmm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	apmm_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_opcode(in_ch.opcode),
		.out_ready(out_ch.ready),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.ctrl(ctrl)
	);

	apmm_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.cfg(cfg),
		.measured_angle(in_ch.measured_angle),
		.base_speed(in_ch.base_speed),
		.first_motor(out_ch.first_motor),
		.second_motor(out_ch.second_motor),
		.drive_value(out_ch.drive_value)
	);

endmodule

FILE: sv/apmm_checker.sv
// apmm_checker: port-level assertions for axis_pi_motor_mixer_top, with its bind
// depends on axis_pi_motor_mixer_top and apmm_pkg
module apmm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_opcode,
	input logic out_valid,
	input logic out_ready,
	input logic [11:0] first_motor,
	input logic [11:0] second_motor,
	input logic signed [13:0] drive_value
);
	import apmm_pkg::*;

	// result transaction stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(first_motor) && $stable(second_motor)
			&& $stable(drive_value))
		else $error("stalled result changed");

	// a control step keeps the input closed while the sequencer runs the step
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == OP_STEP |=> !in_ready)
		else $error("input ready right after a control step");

	// no result can show up in the cycle after a step starts on an empty output
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == OP_STEP && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind axis_pi_motor_mixer_top apmm_checker u_apmm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_opcode(in_ch.opcode),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.first_motor(out_ch.first_motor),
	.second_motor(out_ch.second_motor),
	.drive_value(out_ch.drive_value)
);
